// File: rtl/core/deq_pkg.sv
// shared operation and status codes for the indexed double-ended queue
package deq_pkg;

  // operation codes carried on func_i
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_READ_AT    = 3'd4;

  // status codes returned on status_o
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // field widths fixed by the interface
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 4;

  // response bits handed from the control to the output stage
  typedef struct packed {
    logic       valid;
    logic       ret_data;
    logic [1:0] status;
  } deq_rsp_t;

endpackage

// File: rtl/core/deq_ram.sv
// generic single-port ram with registered read data
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/deq_ctrl.sv
// ring pointers, entry count and ram access generation for the deque
module deq_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [deq_pkg::FUNC_W-1:0]        func_i,
  input  logic [DATA_WIDTH-1:0]             data_in_i,
  input  logic [deq_pkg::POS_W-1:0]         position_i,
  output logic                              ram_we_o,
  output logic [$clog2(DEPTH)-1:0]          ram_addr_o,
  output logic [DATA_WIDTH-1:0]             ram_wdata_o,
  output deq_pkg::deq_rsp_t                 rsp_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned OffW = (CntW > POS_W) ? CntW : POS_W;
  localparam int unsigned SumW = OffW + 1;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] back_idx, last_idx, pos_idx;
  logic            pos_ok;

  // ring index of front plus an offset below the depth
  function automatic logic [IdxW-1:0] ring_at(input logic [IdxW-1:0] base,
                                              input logic [OffW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  // occupancy flags and candidate ring indexes
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - IdxW'(1);
  assign back_idx  = ring_at(front_q, OffW'(count_q));
  assign last_idx  = ring_at(front_q, OffW'(count_q - CntW'(1)));
  assign pos_idx   = ring_at(front_q, OffW'(position_i));
  assign pos_ok    = (OffW'(position_i) < OffW'(count_q));

  // decode one operation into a ram access and the next pointers
  always_comb begin
    front_d         = front_q;
    count_d         = count_q;
    ram_we_o        = 1'b0;
    ram_addr_o      = front_q;
    ram_wdata_o     = data_in_i;
    rsp_o.valid     = start_i;
    rsp_o.ret_data  = 1'b0;
    rsp_o.status    = STATUS_OK;
    if (start_i) begin
      unique case (func_i)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            rsp_o.status = STATUS_FULL;
          end else begin
            front_d    = front_dec;
            count_d    = count_q + CntW'(1);
            ram_we_o   = 1'b1;
            ram_addr_o = front_dec;
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            rsp_o.status = STATUS_FULL;
          end else begin
            count_d    = count_q + CntW'(1);
            ram_we_o   = 1'b1;
            ram_addr_o = back_idx;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            rsp_o.status = STATUS_EMPTY;
          end else begin
            ram_addr_o     = front_q;
            rsp_o.ret_data = 1'b1;
            front_d        = ring_at(front_q, OffW'(1));
            count_d        = count_q - CntW'(1);
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            rsp_o.status = STATUS_EMPTY;
          end else begin
            ram_addr_o     = last_idx;
            rsp_o.ret_data = 1'b1;
            count_d        = count_q - CntW'(1);
          end
        end
        FUNC_READ_AT: begin
          if (!pos_ok) begin
            rsp_o.status = STATUS_EMPTY;
          end else begin
            ram_addr_o     = pos_idx;
            rsp_o.ret_data = 1'b1;
          end
        end
        default: begin
          // unused codes do nothing
        end
      endcase
    end
  end

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/core/double_ended_queue_indexed.sv
// top level of the indexed double-ended queue
//
// A bounded deque of DEPTH words held as a ring in one synchronous ram.
// A command word (func_i, data_in_i, position_i) is taken at a rising
// edge where start_i is high and busy_o is low. Operations: push front,
// push back, pop front, pop back, and read at a position from the front.
// Every command yields exactly one result word on data_out_o, status_o
// and occupancy_o, marked by done_o for one cycle, in the cycle after the
// command edge. The result register lines up with the registered ram read
// data; pointers and count update at the command edge, so a new command
// may be given every cycle and busy_o stays low (throughput 1 per cycle).
// A pop on an empty queue or a read past the count returns status empty
// and zero data; a push into a full queue is dropped with status full.
// Reset clears the front pointer and the count; ram contents are left
// as they are and are never read before being written.
// The receiver cannot hold results off; each done_o cycle must be taken.
module double_ended_queue_indexed #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [deq_pkg::FUNC_W-1:0]   func_i,
  input  logic [DATA_WIDTH-1:0]        data_in_i,
  input  logic [deq_pkg::POS_W-1:0]    position_i,
  output logic                         done_o,
  output logic [DATA_WIDTH-1:0]        data_out_o,
  output logic [1:0]                   status_o,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy_o
);

  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                  ram_we;
  logic [IdxW-1:0]       ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;
  deq_rsp_t              rsp_d, rsp_q;

  // one command word per cycle, never stalled
  assign busy_o = 1'b0;

  // pointer and count control
  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .func_i      (func_i),
    .data_in_i   (data_in_i),
    .position_i  (position_i),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .rsp_o       (rsp_d),
    .count_o     (occupancy_o)
  );

  // entry storage
  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result stage aligned with the ram read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o     = rsp_q.valid;
  assign status_o   = rsp_q.status;
  assign data_out_o = rsp_q.ret_data ? ram_rdata : '0;

endmodule
